// File: rtl/core/smt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and fixed constants of the sphere-map texture coordinate path.
// ----------------------------------------------------------------------------
package smt_pkg;

    // Width of each input component (two's complement)
    localparam int IN_W = 16;
    // Magnitude word after the leading-one shift of the normalizer
    localparam int MAG_W = 32;
    // Texture coordinate width, unsigned Q0.16
    localparam int COORD_W = 16;
    localparam logic [COORD_W-1:0] COORD_HALF = COORD_W'(1) << (COORD_W - 1);
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    typedef struct packed {
        logic signed [IN_W-1:0] pos_x;
        logic signed [IN_W-1:0] pos_y;
        logic signed [IN_W-1:0] pos_z;
        logic signed [IN_W-1:0] norm_x;
        logic signed [IN_W-1:0] norm_y;
        logic signed [IN_W-1:0] norm_z;
    } vtx_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] tex_s;
        logic [COORD_W-1:0] tex_t;
        logic               degenerate;
    } tc_item_t;

endpackage

// File: rtl/core/smt_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module smt_isqrt #(
    parameter int XW = 64,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [XW-1:0]   x,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [XW/2-1:0] root,
    output logic [SW-1:0]   side_out
);

    localparam int RW    = XW / 2;
    localparam int REM_W = RW + 2;
    localparam int TW    = RW + 4;

    logic              valid_reg [1:RW];
    logic [XW-1:0]     x_reg     [1:RW];
    logic [RW-1:0]     root_reg  [1:RW];
    logic [REM_W-1:0]  rem_reg   [1:RW];
    logic [SW-1:0]     side_reg  [1:RW];

    for (genvar j = 0; j < RW; j++) begin : g_step
        logic             cur_valid;
        logic [XW-1:0]    cur_x;
        logic [RW-1:0]    cur_root;
        logic [REM_W-1:0] cur_rem;
        logic [SW-1:0]    cur_side;
        logic [TW-1:0]    t;
        logic [TW-1:0]    trial;
        logic [REM_W-1:0] rem_next;
        logic [RW-1:0]    root_next;

        if (j == 0) begin : g_head
            assign cur_valid = in_valid;
            assign cur_x     = x;
            assign cur_root  = '0;
            assign cur_rem   = '0;
            assign cur_side  = side_in;
        end else begin : g_body
            assign cur_valid = valid_reg[j];
            assign cur_x     = x_reg[j];
            assign cur_root  = root_reg[j];
            assign cur_rem   = rem_reg[j];
            assign cur_side  = side_reg[j];
        end

        // bring in the next bit pair and try 4*root + 1
        always_comb
        begin
            t     = {cur_rem, cur_x[XW-1-2*j -: 2]};
            trial = {2'b00, cur_root, 2'b01};
            if (t >= trial)
            begin
                rem_next  = REM_W'(t - trial);
                root_next = {cur_root[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(t);
                root_next = {cur_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j+1] <= 1'b0;
            else if (en)
                valid_reg[j+1] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j+1]    <= cur_x;
                root_reg[j+1] <= root_next;
                rem_reg[j+1]  <= rem_next;
                side_reg[j+1] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign root      = root_reg[RW];
    assign side_out  = side_reg[RW];

endmodule

// File: rtl/core/smt_vdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_vdiv
// Pipelined restoring divider, one quotient bit per stage, several
// numerators over one shared denominator. The top part of each numerator
// (above the quotient bits) must be below the denominator.
// ----------------------------------------------------------------------------
module smt_vdiv #(
    parameter int L     = 3,
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 16,
    parameter int SW    = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [L-1:0][NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]          den,
    input  logic [SW-1:0]             side_in,
    output logic                      out_valid,
    output logic [L-1:0][Q_W-1:0]     quo,
    output logic [SW-1:0]             side_out
);

    localparam int REM_W = DEN_W + 1;

    logic                    valid_reg [1:Q_W];
    logic [L-1:0][NUM_W-1:0] num_reg   [1:Q_W];
    logic [L-1:0][REM_W-1:0] rem_reg   [1:Q_W];
    logic [L-1:0][Q_W-1:0]   q_reg     [1:Q_W];
    logic [DEN_W-1:0]        den_reg   [1:Q_W];
    logic [SW-1:0]           side_reg  [1:Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        logic                    cur_valid;
        logic [L-1:0][NUM_W-1:0] cur_num;
        logic [L-1:0][REM_W-1:0] cur_rem;
        logic [L-1:0][Q_W-1:0]   cur_q;
        logic [DEN_W-1:0]        cur_den;
        logic [SW-1:0]           cur_side;
        logic [L-1:0][REM_W-1:0] rem_next;
        logic [L-1:0][Q_W-1:0]   q_next;

        if (j == 0) begin : g_head
            always_comb
            begin
                cur_valid = in_valid;
                cur_num   = num;
                cur_den   = den;
                cur_side  = side_in;
                cur_q     = '0;
                for (int l = 0; l < L; l++)
                    cur_rem[l] = REM_W'(num[l] >> Q_W);
            end
        end else begin : g_body
            assign cur_valid = valid_reg[j];
            assign cur_num   = num_reg[j];
            assign cur_rem   = rem_reg[j];
            assign cur_q     = q_reg[j];
            assign cur_den   = den_reg[j];
            assign cur_side  = side_reg[j];
        end

        // shift in one numerator bit and subtract when it fits
        always_comb
        begin
            logic [REM_W-1:0] t;
            t = '0;
            for (int l = 0; l < L; l++)
            begin
                t = {cur_rem[l][REM_W-2:0], cur_num[l][Q_W-1-j]};
                if (t >= {1'b0, cur_den})
                begin
                    rem_next[l] = t - {1'b0, cur_den};
                    q_next[l]   = {cur_q[l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = t;
                    q_next[l]   = {cur_q[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j+1] <= 1'b0;
            else if (en)
                valid_reg[j+1] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[j+1]  <= cur_num;
                rem_reg[j+1]  <= rem_next;
                q_reg[j+1]    <= q_next;
                den_reg[j+1]  <= cur_den;
                side_reg[j+1] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quo       = q_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

// File: rtl/core/smt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_unit
// Vector normalizer: scales a signed 3-vector to a signed Q(FRAC_BITS) unit
// vector. Leading-one shift, sum of squares, square root, then one divide
// per component. A zero vector gives zero.
// ----------------------------------------------------------------------------
module smt_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [2:0][smt_pkg::IN_W-1:0]  vec,
    output logic                           out_valid,
    output logic [2:0][FRAC_BITS+1:0]      uvec
);

    import smt_pkg::*;

    localparam int UW     = FRAC_BITS + 2;
    localparam int SH_W   = $clog2(MAG_W);
    localparam int SQ_W   = 2 * MAG_W;
    localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
    localparam int QW     = FRAC_BITS + 1;
    localparam int SIDE_W = 3 * MAG_W + 4;

    // stage 1: magnitudes and signs
    logic                  s1_valid_reg;
    logic [2:0][MAG_W-1:0] s1_mag_reg, s1_mag_next;
    logic [2:0]            s1_neg_reg, s1_neg_next;
    // stage 2: shift amount
    logic                  s2_valid_reg;
    logic [2:0][MAG_W-1:0] s2_mag_reg;
    logic [2:0]            s2_neg_reg;
    logic                  s2_zero_reg, s2_zero_next;
    logic [SH_W-1:0]       s2_shift_reg, s2_shift_next;
    // stage 3: shifted magnitudes
    logic                  s3_valid_reg;
    logic [2:0][MAG_W-1:0] s3_sh_reg;
    logic [2:0]            s3_neg_reg;
    logic                  s3_zero_reg;
    // stage 4: squares
    logic                  s4_valid_reg;
    logic [2:0][MAG_W-1:0] s4_sh_reg;
    logic [2:0][SQ_W-1:0]  s4_sq_reg;
    logic [2:0]            s4_neg_reg;
    logic                  s4_zero_reg;
    // stage 5: sum of squares
    logic                  s5_valid_reg;
    logic [2:0][MAG_W-1:0] s5_sh_reg;
    logic [SQ_W-1:0]       s5_sum_reg;
    logic [2:0]            s5_neg_reg;
    logic                  s5_zero_reg;
    // square root results
    logic                  rt_valid;
    logic [MAG_W-1:0]      rt_len;
    logic [SIDE_W-1:0]     rt_side;
    logic [2:0][MAG_W-1:0] rt_sh;
    logic [2:0]            rt_neg;
    logic                  rt_zero;
    // stage 6: rounded numerators
    logic                  s6_valid_reg;
    logic [2:0][NUM_W-1:0] s6_num_reg, s6_num_next;
    logic [MAG_W-1:0]      s6_len_reg;
    logic [2:0]            s6_neg_reg;
    logic                  s6_zero_reg;
    // divider results
    logic                  dv_valid;
    logic [2:0][QW-1:0]    dv_quo;
    logic [3:0]            dv_side;
    // stage 7: signed components
    logic                  s7_valid_reg;
    logic [2:0][UW-1:0]    s7_u_reg, s7_u_next;

    // take magnitudes of the components
    always_comb
    begin
        logic signed [MAG_W-1:0] sx;
        sx = '0;
        for (int i = 0; i < 3; i++)
        begin
            sx             = MAG_W'($signed(vec[i]));
            s1_neg_next[i] = vec[i][IN_W-1];
            s1_mag_next[i] = vec[i][IN_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
        end
    end

    // find the shift that lifts the largest magnitude above 2^30
    always_comb
    begin
        logic [MAG_W-1:0] mx;
        logic [SH_W-1:0]  msb;
        logic             pow2;
        mx = s1_mag_reg[0];
        if (s1_mag_reg[1] > mx)
            mx = s1_mag_reg[1];
        if (s1_mag_reg[2] > mx)
            mx = s1_mag_reg[2];
        msb = '0;
        for (int b = 0; b < MAG_W; b++)
            if (mx[b])
                msb = SH_W'(b);
        pow2         = ((mx & (mx - 1'b1)) == '0);
        s2_zero_next = (mx == '0);
        if (msb == SH_W'(MAG_W - 1))
            s2_shift_next = '0;
        else
            s2_shift_next = SH_W'(MAG_W - 2) - msb + SH_W'(pow2);
    end

    // form len/2-rounded numerators for the divide
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s6_num_next[i] = (NUM_W'(rt_sh[i]) << FRAC_BITS)
                           + NUM_W'(rt_len[MAG_W-1:1]);
    end

    // restore signs, force zero for a null vector
    always_comb
    begin
        logic [UW-1:0] qx;
        qx = '0;
        for (int i = 0; i < 3; i++)
        begin
            qx = UW'(dv_quo[i]);
            if (dv_side[0])
                s7_u_next[i] = '0;
            else if (dv_side[i+1])
                s7_u_next[i] = -qx;
            else
                s7_u_next[i] = qx;
        end
    end

    assign {rt_sh, rt_neg, rt_zero} = rt_side;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= rt_valid;
            s7_valid_reg <= dv_valid;
        end
    end

    // advance data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= s1_neg_next;
            s2_mag_reg   <= s1_mag_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_zero_reg  <= s2_zero_next;
            s2_shift_reg <= s2_shift_next;
            for (int i = 0; i < 3; i++)
            begin
                s3_sh_reg[i] <= s2_mag_reg[i] << s2_shift_reg;
                s4_sq_reg[i] <= SQ_W'(s3_sh_reg[i]) * SQ_W'(s3_sh_reg[i]);
            end
            s3_neg_reg  <= s2_neg_reg;
            s3_zero_reg <= s2_zero_reg;
            s4_sh_reg   <= s3_sh_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_zero_reg <= s3_zero_reg;
            s5_sh_reg   <= s4_sh_reg;
            s5_sum_reg  <= s4_sq_reg[0] + s4_sq_reg[1] + s4_sq_reg[2];
            s5_neg_reg  <= s4_neg_reg;
            s5_zero_reg <= s4_zero_reg;
            s6_num_reg  <= s6_num_next;
            s6_len_reg  <= rt_len;
            s6_neg_reg  <= rt_neg;
            s6_zero_reg <= rt_zero;
            s7_u_reg    <= s7_u_next;
        end
    end

    smt_isqrt #(
        .XW (SQ_W),
        .SW (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .x         (s5_sum_reg),
        .side_in   ({s5_sh_reg, s5_neg_reg, s5_zero_reg}),
        .out_valid (rt_valid),
        .root      (rt_len),
        .side_out  (rt_side)
    );

    smt_vdiv #(
        .L     (3),
        .NUM_W (NUM_W),
        .DEN_W (MAG_W),
        .Q_W   (QW),
        .SW    (4)
    ) u_vdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .num       (s6_num_reg),
        .den       (s6_len_reg),
        .side_in   ({s6_neg_reg, s6_zero_reg}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    assign out_valid = s7_valid_reg;
    assign uvec      = s7_u_reg;

endmodule

// File: rtl/core/smt_refl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_refl
// Reflection r = u - 2n(n.u) with fixed-point rounding, then the root of
// rx^2 + ry^2 + (rz+1)^2.
// ----------------------------------------------------------------------------
module smt_refl #(
    parameter int FRAC_BITS = 14
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2:0][FRAC_BITS+1:0] u,
    input  logic [2:0][FRAC_BITS+1:0] n,
    output logic                      out_valid,
    output logic [FRAC_BITS+4:0]      r_x,
    output logic [FRAC_BITS+4:0]      r_y,
    output logic [FRAC_BITS+5:0]      root
);

    localparam int UW   = FRAC_BITS + 2;
    localparam int PW   = 2 * UW;
    localparam int DW   = 2 * FRAC_BITS + 6;
    localparam int DQW  = FRAC_BITS + 4;
    localparam int TW   = UW + DQW + 1;
    localparam int RW   = FRAC_BITS + 5;
    localparam int SQ1W = 2 * RW;
    localparam int SQW  = SQ1W + 2;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [2:0][UW-1:0]      u1_reg, u2_reg, u3_reg, u4_reg;
    logic [2:0][UW-1:0]      n1_reg, n2_reg, n3_reg;
    logic signed [PW-1:0]    pr1_reg [3];
    logic signed [DW-1:0]    d2_reg;
    logic signed [DQW-1:0]   dq3_reg, dq3_next;
    logic signed [TW-1:0]    t4_reg [3];
    logic signed [RW-1:0]    r5_reg [3];
    logic signed [RW-1:0]    r5_next [3];
    logic signed [RW-1:0]    rx6_reg, ry6_reg, rx7_reg, ry7_reg;
    logic [SQ1W-1:0]         sq6_reg [3];
    logic [SQW-1:0]          sum7_reg;
    logic signed [RW-1:0]    rz1;

    // round the dot product to Q(FRAC_BITS), halves away from zero
    always_comb
    begin
        logic [DW-1:0] dabs;
        logic [DW-1:0] drnd;
        dabs = d2_reg[DW-1] ? DW'(-d2_reg) : DW'(d2_reg);
        drnd = (dabs + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        dq3_next = d2_reg[DW-1] ? -DQW'(drnd) : DQW'(drnd);
    end

    // round each 2 n_i (n.u) term and subtract from u_i
    always_comb
    begin
        logic signed [TW-1:0] tv;
        logic [TW-1:0]        tabs;
        logic [TW-1:0]        trnd;
        logic signed [RW-1:0] tq;
        tv   = '0;
        tabs = '0;
        trnd = '0;
        tq   = '0;
        for (int i = 0; i < 3; i++)
        begin
            tv   = t4_reg[i] <<< 1;
            tabs = tv[TW-1] ? TW'(-tv) : TW'(tv);
            trnd = (tabs + (TW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            tq   = tv[TW-1] ? -RW'(trnd) : RW'(trnd);
            r5_next[i] = RW'($signed(u4_reg[i])) - tq;
        end
    end

    assign rz1 = r5_reg[2] + (RW'(1) << FRAC_BITS);

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // advance data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr1_reg[i] <= $signed(n[i]) * $signed(u[i]);
                t4_reg[i]  <= TW'($signed(n3_reg[i])) * TW'(dq3_reg);
                r5_reg[i]  <= r5_next[i];
            end
            u1_reg   <= u;
            n1_reg   <= n;
            u2_reg   <= u1_reg;
            n2_reg   <= n1_reg;
            d2_reg   <= DW'(pr1_reg[0]) + DW'(pr1_reg[1]) + DW'(pr1_reg[2]);
            u3_reg   <= u2_reg;
            n3_reg   <= n2_reg;
            dq3_reg  <= dq3_next;
            u4_reg   <= u3_reg;
            rx6_reg  <= r5_reg[0];
            ry6_reg  <= r5_reg[1];
            sq6_reg[0] <= SQ1W'(r5_reg[0] * r5_reg[0]);
            sq6_reg[1] <= SQ1W'(r5_reg[1] * r5_reg[1]);
            sq6_reg[2] <= SQ1W'(rz1 * rz1);
            rx7_reg  <= rx6_reg;
            ry7_reg  <= ry6_reg;
            sum7_reg <= SQW'(sq6_reg[0]) + SQW'(sq6_reg[1]) + SQW'(sq6_reg[2]);
        end
    end

    smt_isqrt #(
        .XW (SQW),
        .SW (2 * RW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .x         (sum7_reg),
        .side_in   ({rx7_reg, ry7_reg}),
        .out_valid (out_valid),
        .root      (root),
        .side_out  ({r_x, r_y})
    );

endmodule

// File: rtl/core/smt_coord.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_coord
// Texture coordinates s = rx/m + 1/2 and t = ry/m + 1/2 with rounding and
// saturation; m = 2*root, replaced by one when the root is zero.
// ----------------------------------------------------------------------------
module smt_coord #(
    parameter int FRAC_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [FRAC_BITS+4:0]  r_x,
    input  logic [FRAC_BITS+4:0]  r_y,
    input  logic [FRAC_BITS+5:0]  root,
    output logic                  out_valid,
    output smt_pkg::tc_item_t     out_item
);

    import smt_pkg::*;

    localparam int RW  = FRAC_BITS + 5;
    localparam int MW  = FRAC_BITS + 7;
    localparam int AW  = RW + COORD_W + 1;

    logic                   c1_valid_reg, c2_valid_reg, out_valid_reg;
    logic [1:0][AW-1:0]     c1_a_reg, c1_a_next;
    logic [MW-1:0]          c1_m_reg, c1_m_next;
    logic [1:0]             c1_neg_reg, c1_neg_next;
    logic                   c1_deg_reg;
    logic [1:0][AW-1:0]     c2_num_reg, c2_num_next;
    logic [MW-1:0]          c2_m_reg;
    logic [1:0]             c2_neg_reg;
    logic [1:0]             c2_ovf_reg, c2_ovf_next;
    logic                   c2_deg_reg;
    logic                   dv_valid;
    logic [1:0][COORD_W-1:0] dv_quo;
    logic [4:0]             dv_side;
    tc_item_t               out_item_reg, out_item_next;

    // pick m and form |r| * 2^16 + m/2
    always_comb
    begin
        logic signed [RW-1:0] rv [2];
        logic [RW-1:0]        ra;
        rv[0] = $signed(r_x);
        rv[1] = $signed(r_y);
        ra    = '0;
        c1_m_next = (root == '0) ? (MW'(1) << FRAC_BITS) : {root, 1'b0};
        for (int i = 0; i < 2; i++)
        begin
            c1_neg_next[i] = rv[i][RW-1];
            ra = rv[i][RW-1] ? RW'(-rv[i]) : RW'(rv[i]);
            c1_a_next[i] = (AW'(ra) << COORD_W) + AW'(c1_m_next[MW-1:1]);
        end
    end

    // flag quotients of 2^16 and more, clear their numerators
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            c2_ovf_next[i] = (c1_a_reg[i] >> COORD_W) >= AW'(c1_m_reg);
            c2_num_next[i] = c2_ovf_next[i] ? '0 : c1_a_reg[i];
        end
    end

    // add the half offset and saturate
    always_comb
    begin
        logic [COORD_W-1:0] c [2];
        for (int i = 0; i < 2; i++)
        begin
            if (dv_side[i+3])
            begin
                if (dv_side[i+1] || dv_quo[i] > COORD_HALF)
                    c[i] = '0;
                else
                    c[i] = COORD_HALF - dv_quo[i];
            end
            else
            begin
                if (dv_side[i+1] || dv_quo[i][COORD_W-1])
                    c[i] = COORD_MAX;
                else
                    c[i] = dv_quo[i] | COORD_HALF;
            end
        end
        out_item_next.tex_s      = c[0];
        out_item_next.tex_t      = c[1];
        out_item_next.degenerate = dv_side[0];
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg  <= in_valid;
            c2_valid_reg  <= c1_valid_reg;
            out_valid_reg <= dv_valid;
        end
    end

    // advance data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_a_reg     <= c1_a_next;
            c1_m_reg     <= c1_m_next;
            c1_neg_reg   <= c1_neg_next;
            c1_deg_reg   <= (root == '0);
            c2_num_reg   <= c2_num_next;
            c2_m_reg     <= c1_m_reg;
            c2_neg_reg   <= c1_neg_reg;
            c2_ovf_reg   <= c2_ovf_next;
            c2_deg_reg   <= c1_deg_reg;
            out_item_reg <= out_item_next;
        end
    end

    smt_vdiv #(
        .L     (2),
        .NUM_W (AW),
        .DEN_W (MW),
        .Q_W   (COORD_W),
        .SW    (5)
    ) u_vdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid_reg),
        .num       (c2_num_reg),
        .den       (c2_m_reg),
        .side_in   ({c2_neg_reg, c2_ovf_reg, c2_deg_reg}),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: rtl/core/sphere_map_texcoord_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_map_texcoord_gen
// Sphere-map texture coordinates from eye-space position and normal.
//
//   channel   valid      ready      payload   direction
//   vertex    vtx_valid  vtx_ready  vtx       in
//   texcoord  tc_valid   tc_ready   tc        out
//
// One vertex enters per clock while the output is not stalled; the depth is
// set by the bit-per-stage square roots in the normalizers and reflection and
// the bit-per-stage dividers in the normalizers and the coordinate step.
// rst_n clears all valid bits; no clearing pass is needed.
// While tc_valid is high and tc_ready is low the whole pipeline holds and
// vtx_ready is low.
// ----------------------------------------------------------------------------
module sphere_map_texcoord_gen #(
    parameter int FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vtx_valid,
    output logic               vtx_ready,
    input  smt_pkg::vtx_item_t vtx,
    output logic               tc_valid,
    input  logic               tc_ready,
    output smt_pkg::tc_item_t  tc
);

    import smt_pkg::*;

    localparam int UW = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 5;

    logic                en;
    logic                pos_valid, norm_valid;
    logic [2:0][UW-1:0]  u_vec, n_vec;
    logic                rf_valid;
    logic [RW-1:0]       rf_x, rf_y;
    logic [RW:0]         rf_root;

    // freeze every stage while the output item waits
    assign en        = ~tc_valid | tc_ready;
    assign vtx_ready = en;

    smt_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vtx_valid),
        .vec       ({vtx.pos_z, vtx.pos_y, vtx.pos_x}),
        .out_valid (pos_valid),
        .uvec      (u_vec)
    );

    smt_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vtx_valid),
        .vec       ({vtx.norm_z, vtx.norm_y, vtx.norm_x}),
        .out_valid (norm_valid),
        .uvec      (n_vec)
    );

    smt_refl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_refl (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pos_valid & norm_valid),
        .u         (u_vec),
        .n         (n_vec),
        .out_valid (rf_valid),
        .r_x       (rf_x),
        .r_y       (rf_y),
        .root      (rf_root)
    );

    smt_coord #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rf_valid),
        .r_x       (rf_x),
        .r_y       (rf_y),
        .root      (rf_root),
        .out_valid (tc_valid),
        .out_item  (tc)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertices into sphere_map_texcoord_gen with random gaps and output
// stalls. A bit-exact fixed-point predictor computes the expected texture
// coordinates, and a scoreboard compares each result in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    import smt_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = 2 * FRAC + 72;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 900;

    // ------------------------------------------------------------------------
    // Coordinate predictor and store of expected coordinates
    // ------------------------------------------------------------------------
    class texcoord_scoreboard;
        tc_item_t pending[$];
        int       n_errors = 0;

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= root + bitv)
                begin
                    x = x - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // round(num/den), halves away from zero
        function longint round_div(longint num, longint unsigned den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? longint'(-num) : longint'(num);
            q = (mag + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void unit_vector(input longint v[3], output longint u[3]);
            longint unsigned mag[3];
            longint unsigned peak;
            longint unsigned sumsq;
            longint unsigned len;
            longint unsigned q;
            peak = 0;
            sumsq = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
                if (mag[i] > peak)
                    peak = mag[i];
            end
            if (peak == 0)
            begin
                u[0] = 0;
                u[1] = 0;
                u[2] = 0;
                return;
            end
            while (peak <= (64'd1 << 30))
            begin
                peak = peak << 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
            end
            for (int i = 0; i < 3; i++)
                sumsq += mag[i] * mag[i];
            len = int_sqrt(sumsq);
            for (int i = 0; i < 3; i++)
            begin
                q = ((mag[i] << FRAC) + len / 2) / len;
                u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        function logic [COORD_W-1:0] coord(longint c, longint unsigned m);
            longint v;
            v = round_div(c * 65536, m) + 32768;
            if (v < 0)
                return '0;
            if (v > 65535)
                return COORD_MAX;
            return v[COORD_W-1:0];
        endfunction

        function tc_item_t sphere_map(vtx_item_t vx);
            longint p[3];
            longint nv[3];
            longint u[3];
            longint n[3];
            longint r[3];
            longint dot;
            longint dq;
            longint rz1;
            longint unsigned msq;
            longint unsigned m;
            tc_item_t res;
            p = '{longint'(vx.pos_x), longint'(vx.pos_y), longint'(vx.pos_z)};
            nv = '{longint'(vx.norm_x), longint'(vx.norm_y), longint'(vx.norm_z)};
            unit_vector(p, u);
            unit_vector(nv, n);
            dot = 0;
            for (int i = 0; i < 3; i++)
                dot += n[i] * u[i];
            dq = round_div(dot, 64'd1 << FRAC);
            for (int i = 0; i < 3; i++)
                r[i] = u[i] - round_div(2 * n[i] * dq, 64'd1 << FRAC);
            rz1 = r[2] + (longint'(1) << FRAC);
            msq = int_sqrt(r[0] * r[0] + r[1] * r[1] + rz1 * rz1);
            res.degenerate = (msq == 0);
            m = (msq == 0) ? (64'd1 << FRAC) : 2 * msq;
            res.tex_s = coord(r[0], m);
            res.tex_t = coord(r[1], m);
            return res;
        endfunction

        function void note_vertex(vtx_item_t vx);
            pending.push_back(sphere_map(vx));
        endfunction

        function void check_texcoord(tc_item_t got);
            tc_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected texcoord s=%h t=%h deg=%b", $realtime,
                         got.tex_s, got.tex_t, got.degenerate);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            if (got.tex_s !== want.tex_s)
            begin
                $display("%0t: tex_s expected %h actual %h", $realtime,
                         want.tex_s, got.tex_s);
                n_errors++;
            end
            if (got.tex_t !== want.tex_t)
            begin
                $display("%0t: tex_t expected %h actual %h", $realtime,
                         want.tex_t, got.tex_t);
                n_errors++;
            end
            if (got.degenerate !== want.degenerate)
            begin
                $display("%0t: degenerate expected %b actual %b", $realtime,
                         want.degenerate, got.degenerate);
                n_errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       vtx_valid = 1'b0;
    logic       vtx_ready;
    vtx_item_t  vtx = '0;
    logic       tc_valid;
    logic       tc_ready = 1'b0;
    tc_item_t   tc;

    texcoord_scoreboard sb = new();
    bit         stim_done = 1'b0;
    int         idle_cycles = 0;

    sphere_map_texcoord_gen #(.FRAC_BITS(FRAC)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .tc_valid  (tc_valid),
        .tc_ready  (tc_ready),
        .tc        (tc)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap length: mostly none or short, occasionally long
    function int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function logic signed [IN_W-1:0] rand_comp();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return IN_W'($signed($urandom_range(0, 6)) - 3);
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Present one vertex and hold it until accepted; valid stays high
    // afterwards so that items can follow back to back
    task automatic send_vertex(vtx_item_t vx, bit with_gap);
        int gap;
        gap = with_gap ? gap_len() : 0;
        if (gap != 0)
        begin
            vtx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vtx <= vx;
        vtx_valid <= 1'b1;
        do
            @(posedge clk);
        while (!vtx_ready);
        sb.note_vertex(vx);
        @(negedge clk);
    endtask

    function vtx_item_t mk(int px, int py, int pz, int nx, int ny, int nz);
        vtx_item_t vx;
        vx.pos_x = IN_W'(px);
        vx.pos_y = IN_W'(py);
        vx.pos_z = IN_W'(pz);
        vx.norm_x = IN_W'(nx);
        vx.norm_y = IN_W'(ny);
        vx.norm_z = IN_W'(nz);
        return vx;
    endfunction

    // Stimulus
    initial
    begin
        vtx_item_t vx;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero vectors, extremes, degenerate reflection, saturation
        send_vertex(mk(0, 0, 0, 0, 0, 0), 0);
        send_vertex(mk(0, 0, 0, 1, 2, 3), 0);
        send_vertex(mk(1, 2, -3, 0, 0, 0), 0);
        send_vertex(mk(0, 0, -1, 0, 0, 1), 0);
        send_vertex(mk(0, 0, -100, 0, 0, 0), 0);
        send_vertex(mk(0, 0, 1, 0, 0, 1), 0);
        send_vertex(mk(0, 0, 32767, 0, 0, -32768), 0);
        send_vertex(mk(-32768, -32768, -32768, -32768, -32768, -32768), 0);
        send_vertex(mk(32767, 32767, 32767, 32767, 32767, 32767), 0);
        send_vertex(mk(-32768, 32767, -32768, 32767, -32768, 32767), 0);
        send_vertex(mk(32767, 0, 0, 0, 0, 1), 0);
        send_vertex(mk(-32768, 0, 0, 0, 0, 1), 0);
        send_vertex(mk(0, 32767, 0, 0, 0, 1), 0);
        send_vertex(mk(0, -32768, 0, 0, 0, 1), 0);
        send_vertex(mk(1, 0, -1, 0, 0, 1), 0);
        send_vertex(mk(1, 1, 1, 1, -1, 1), 0);
        send_vertex(mk(-1, -1, -1, -1, -1, -1), 0);
        send_vertex(mk(0, 0, -32768, 1, 0, 1), 0);
        send_vertex(mk(3, -5, 7, 0, 32767, 0), 0);
        send_vertex(mk(-21845, 21845, -10922, 5461, -5461, 16383), 0);

        // Random vertices; hold off once until the pipeline drains
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                vtx_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(negedge clk);
            end
            vx.pos_x = rand_comp();
            vx.pos_y = rand_comp();
            vx.pos_z = rand_comp();
            vx.norm_x = rand_comp();
            vx.norm_y = rand_comp();
            vx.norm_z = rand_comp();
            send_vertex(vx, i > 100);
        end
        vtx_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Output stalls
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 4) == 0) ? gap_len() : 0;
            if (gap != 0)
            begin
                tc_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            tc_ready <= 1'b1;
        end
    end

    // Check each texcoord item as it is accepted
    always @(posedge clk)
    begin
        if (rst_n && tc_valid && tc_ready)
            sb.check_texcoord(tc);
    end

    // Watchdog: count cycles with no item moving
    always @(posedge clk)
    begin
        if ((vtx_valid && vtx_ready) || (tc_valid && tc_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Finish
    initial
    begin
        @(posedge rst_n);
        fork
            begin
                wait (stim_done && sb.pending.size() == 0);
                repeat (LATENCY + 20) @(posedge clk);
                if (sb.n_errors == 0 && sb.pending.size() == 0)
                    $display("** sphere_map_texcoord_gen: PASSED **");
                else
                    $display("** sphere_map_texcoord_gen: FAILED **");
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                $display("%0t: watchdog timeout", $realtime);
                $display("** sphere_map_texcoord_gen: FAILED **");
            end
        join_any
        $finish;
    end

endmodule
